### hw/rtl/sws_pkg.sv
// ----------------------------------------------------------------------------
// sws_pkg
// Types and constants shared by the shell word splitter modules.
// ----------------------------------------------------------------------------
package sws_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned WcntW  = 7;
  localparam int unsigned Slots  = 3;
  localparam int unsigned SlotW  = 2;

  localparam logic [CharW-1:0] ChSpace  = 8'h20;
  localparam logic [CharW-1:0] ChTab    = 8'h09;
  localparam logic [CharW-1:0] ChNl     = 8'h0a;
  localparam logic [CharW-1:0] ChDollar = 8'h24;
  localparam logic [CharW-1:0] ChBtick  = 8'h60;
  localparam logic [CharW-1:0] ChBslash = 8'h5c;
  localparam logic [CharW-1:0] ChSq     = 8'h27;
  localparam logic [CharW-1:0] ChDq     = 8'h22;

  typedef enum logic [1:0] {
    KIND_CHAR     = 2'd0,
    KIND_WORD_END = 2'd1,
    KIND_LINE_END = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e            kind;
    logic [CharW-1:0] ch;
  } res_t;

  // all results caused by one input word, oldest in slot 0
  typedef struct packed {
    logic [SlotW-1:0] cnt;
    res_t [Slots-1:0] res;
  } bundle_t;

  typedef struct packed {
    logic             in_word;
    logic             sq;
    logic             dq;
    logic             esc;
    logic             dq_esc;
    logic [WcntW-1:0] wcnt;
    logic             capped;
  } split_st_t;

endpackage

### hw/rtl/sws_front.sv
// ----------------------------------------------------------------------------
// sws_front
// Classifies each input word, updates the quoting state and builds the
// bundle of results it causes.
// ----------------------------------------------------------------------------
module sws_front #(
  parameter int unsigned MAX_WORDS = 99
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     accept_i,
  input  logic [sws_pkg::CharW-1:0] ch_i,
  input  logic                     line_end_i,
  output logic                     wr_en_o,
  output sws_pkg::bundle_t         bundle_o
);
  import sws_pkg::*;

  split_st_t        st_q, st_d;
  bundle_t          bnd;
  logic [SlotW-1:0] k;
  logic [WcntW-1:0] wcnt_inc;

  function automatic res_t mk_res(kind_e kind, logic [CharW-1:0] ch);
    res_t r;
    r.kind = kind;
    r.ch   = ch;
    return r;
  endfunction

  assign wcnt_inc = st_q.wcnt + WcntW'(1);

  always_comb begin
    st_d = st_q;
    bnd  = '0;
    k    = '0;
    if (line_end_i) begin
      if (st_q.dq_esc && !st_q.capped) begin
        bnd.res[k] = mk_res(KIND_CHAR, ChBslash);
        k = k + SlotW'(1);
      end
      if (st_q.in_word && !st_q.capped) begin
        bnd.res[k] = mk_res(KIND_WORD_END, '0);
        k = k + SlotW'(1);
      end
      bnd.res[k] = mk_res(KIND_LINE_END, '0);
      k = k + SlotW'(1);
      st_d = '0;
    end else if (st_q.capped) begin
      k = '0;
    end else if (st_q.esc) begin
      st_d.esc   = 1'b0;
      bnd.res[0] = mk_res(KIND_CHAR, ch_i);
      k = SlotW'(1);
    end else if (st_q.dq_esc) begin
      st_d.dq_esc = 1'b0;
      if (ch_i == ChDq || ch_i == ChBslash || ch_i == ChDollar || ch_i == ChBtick) begin
        bnd.res[0] = mk_res(KIND_CHAR, ch_i);
        k = SlotW'(1);
      end else if (ch_i != ChNl) begin
        // backslash stays literal before an ordinary character
        bnd.res[0] = mk_res(KIND_CHAR, ChBslash);
        bnd.res[1] = mk_res(KIND_CHAR, ch_i);
        k = SlotW'(2);
      end
    end else if (st_q.sq) begin
      if (ch_i == ChSq) begin
        st_d.sq = 1'b0;
      end else begin
        bnd.res[0] = mk_res(KIND_CHAR, ch_i);
        k = SlotW'(1);
      end
    end else if (st_q.dq) begin
      if (ch_i == ChDq) begin
        st_d.dq = 1'b0;
      end else if (ch_i == ChBslash) begin
        st_d.dq_esc = 1'b1;
      end else begin
        bnd.res[0] = mk_res(KIND_CHAR, ch_i);
        k = SlotW'(1);
      end
    end else if (ch_i == ChSpace || ch_i == ChTab) begin
      if (st_q.in_word) begin
        bnd.res[0]    = mk_res(KIND_WORD_END, '0);
        k             = SlotW'(1);
        st_d.in_word  = 1'b0;
        st_d.wcnt     = wcnt_inc;
        st_d.capped   = (wcnt_inc >= WcntW'(MAX_WORDS));
      end
    end else begin
      st_d.in_word = 1'b1;
      if (ch_i == ChBslash) begin
        st_d.esc = 1'b1;
      end else if (ch_i == ChSq) begin
        st_d.sq = 1'b1;
      end else if (ch_i == ChDq) begin
        st_d.dq = 1'b1;
      end else begin
        bnd.res[0] = mk_res(KIND_CHAR, ch_i);
        k = SlotW'(1);
      end
    end
    bnd.cnt = k;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (accept_i) begin
      st_q <= st_d;
    end
  end

  assign wr_en_o  = accept_i && (bnd.cnt != '0);
  assign bundle_o = bnd;

endmodule

### hw/rtl/sws_queue.sv
// ----------------------------------------------------------------------------
// sws_queue
// Short bundle queue between the classifier and the result serializer.
// ----------------------------------------------------------------------------
module sws_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  sws_pkg::bundle_t wr_data_i,
  output logic             full_o,
  input  logic             rd_en_i,
  output logic             valid_o,
  output sws_pkg::bundle_t rd_data_o
);
  import sws_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  bundle_t         mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_wr, do_rd;

  assign full_o    = (cnt_q == CntW'(DEPTH));
  assign valid_o   = (cnt_q != '0);
  assign rd_data_o = mem_q[rd_ptr_q];
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

### hw/rtl/sws_back.sv
// ----------------------------------------------------------------------------
// sws_back
// Walks the slots of the head bundle and loads one result per cycle into
// the output register while that register is empty or being popped.
// ----------------------------------------------------------------------------
module sws_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      q_valid_i,
  input  sws_pkg::bundle_t          q_data_i,
  output logic                      q_pop_o,
  input  logic                      pop,
  output logic                      empty,
  output logic [1:0]                kind_o,
  output logic [sws_pkg::CharW-1:0] out_char_o,
  output logic                      last_o
);
  import sws_pkg::*;

  logic [SlotW-1:0] idx_q, idx_d;
  logic             ovld_q, ovld_d;
  res_t             ores_q, ores_d;
  logic             olast_q, olast_d;
  logic             load, slot_last;

  assign slot_last = (idx_q == (q_data_i.cnt - SlotW'(1)));
  // output register frees up when empty or being popped this cycle
  assign load      = q_valid_i && (!ovld_q || pop);
  assign q_pop_o   = load && slot_last;

  always_comb begin
    idx_d   = idx_q;
    ovld_d  = ovld_q;
    ores_d  = ores_q;
    olast_d = olast_q;
    if (pop && ovld_q) begin
      ovld_d = 1'b0;
    end
    if (load) begin
      ovld_d  = 1'b1;
      ores_d  = q_data_i.res[idx_q];
      olast_d = slot_last;
      idx_d   = slot_last ? '0 : idx_q + SlotW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      ovld_q <= 1'b0;
    end else begin
      idx_q  <= idx_d;
      ovld_q <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ores_q  <= ores_d;
    olast_q <= olast_d;
  end

  assign empty      = !ovld_q;
  assign kind_o     = ores_q.kind;
  assign out_char_o = ores_q.ch;
  assign last_o     = olast_q;

endmodule

### hw/rtl/shell_word_splitter_core.sv
// ----------------------------------------------------------------------------
// shell_word_splitter_core
// Splits a command line into words with shell-style quote removal.
// ----------------------------------------------------------------------------
// Input side is a queue write port: drive ch_i / line_end_i with push; the
// word is taken on a clock edge with push high and full low. One character
// is taken every cycle while the bundle queue has room.
// Result side is a queue read port: while empty is low, kind_o / out_char_o
// / last_o show the oldest result; it is taken on an edge with pop high.
// Each input word yields zero to three results; last_o marks the final one.
// A result is written into the bundle queue at its input edge and then
// loaded into the output register once that register is free. Results
// leave at one per cycle while pop is high, so a character that expands to
// two or three results needs one pop per result; the DEPTH-entry bundle
// queue absorbs such bursts and stalls of pop; full rises only when filled.
// Reset clears the quoting state, word counter, queue and output valid flag;
// nothing is pending afterwards. A line end returns all splitting state
// to its reset value.
// ----------------------------------------------------------------------------
module shell_word_splitter_core #(
  parameter int unsigned MAX_WORDS = 99,
  parameter int unsigned DEPTH     = 4
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push,
  output logic                      full,
  input  logic [sws_pkg::CharW-1:0] ch_i,
  input  logic                      line_end_i,
  output logic                      empty,
  input  logic                      pop,
  output logic [1:0]                kind_o,
  output logic [sws_pkg::CharW-1:0] out_char_o,
  output logic                      last_o
);
  import sws_pkg::*;

  logic    accept, wr_en, q_valid, q_pop;
  bundle_t wr_bundle, q_head;

  assign accept = push && !full;

  sws_front #(
    .MAX_WORDS (MAX_WORDS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .ch_i       (ch_i),
    .line_end_i (line_end_i),
    .wr_en_o    (wr_en),
    .bundle_o   (wr_bundle)
  );

  sws_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_data_i (wr_bundle),
    .full_o    (full),
    .rd_en_i   (q_pop),
    .valid_o   (q_valid),
    .rd_data_o (q_head)
  );

  sws_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_data_i   (q_head),
    .q_pop_o    (q_pop),
    .pop        (pop),
    .empty      (empty),
    .kind_o     (kind_o),
    .out_char_o (out_char_o),
    .last_o     (last_o)
  );

endmodule

### hw/rtl/sws_checker.sv
// ----------------------------------------------------------------------------
// sws_checker
// Port-level checks of the shell word splitter result stream.
// ----------------------------------------------------------------------------
module sws_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      empty,
  input logic                      pop,
  input logic [1:0]                kind_o,
  input logic [sws_pkg::CharW-1:0] out_char_o,
  input logic                      last_o
);
  import sws_pkg::*;

  // a waiting result holds until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(kind_o) && $stable(out_char_o)
                          && $stable(last_o)))
    else $error("result changed while stalled");

  // markers carry no character
  a_marker_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o != KIND_CHAR) |-> (out_char_o == '0))
    else $error("marker with nonzero character");

  // line end is always the final result of its input word
  a_line_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o == KIND_LINE_END) |-> last_o)
    else $error("line end not marked last");

  // a word end that is not last in its bundle is followed by a line end or empty
  a_word_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && kind_o == KIND_WORD_END && !last_o && pop) |=>
      (empty || kind_o == KIND_LINE_END))
    else $error("word end followed by wrong result");

endmodule

bind shell_word_splitter_core sws_checker u_sws_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .empty      (empty),
  .pop        (pop),
  .kind_o     (kind_o),
  .out_char_o (out_char_o),
  .last_o     (last_o)
);
